/* sv/wsm_pkg.sv */
package wsm_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic signed [23:0] mono_sample;
        logic               sample_valid;
        logic               done_res;
        logic [3:0]         status;
        logic [31:0]        sample_rate;
    } t_out;

    // parser to controller
    typedef struct packed {
        logic        give;
        logic [3:0]  status;
        logic [31:0] rate;
    } t_pstat;

    // controller to parser
    typedef struct packed {
        logic clear;
    } t_cmd;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_NOT_RIFF = 4'd2;
    localparam logic [3:0] ST_MISSING  = 4'd3;
    localparam logic [3:0] ST_RATE_CH  = 4'd4;
    localparam logic [3:0] ST_FORMAT   = 4'd5;
    localparam logic [3:0] ST_DEPTH    = 4'd6;
    localparam logic [3:0] ST_PCM_DEP  = 4'd7;
    localparam logic [3:0] ST_FLT_DEP  = 4'd8;
    localparam logic [3:0] ST_BAD_DATA = 4'd9;
    localparam logic [3:0] ST_FEW      = 4'd10;

    localparam int DIV_W = 7;

endpackage

/* sv/wsm_div.sv */
module wsm_div import wsm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [35:0]      i_dividend,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [23:0]      o_quot
);
    localparam int QW = 37;

    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [DIV_W-1:0] r_d;
    logic [DIV_W-1:0] r_rem;
    logic [QW-1:0]    r_q;

    logic [QW-1:0]    start_mag;
    logic [DIV_W:0]   rem_sh;
    logic             qbit;

    always_comb begin
        start_mag = {i_dividend[35], i_dividend};
        if (i_dividend[35]) begin
            start_mag = QW'(0) - start_mag + QW'(i_divisor) - QW'(1);
        end
        rem_sh = {r_rem, r_q[QW-1]};
        qbit   = rem_sh >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[35];
            r_d   <= i_divisor;
            r_rem <= '0;
            r_q   <= start_mag;
        end else if (r_busy) begin
            r_rem <= qbit ? DIV_W'(rem_sh - {1'b0, r_d}) : rem_sh[DIV_W-1:0];
            r_q   <= {r_q[QW-2:0], qbit};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q > QW'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(r_q[23:0]);
        end else begin
            o_quot = (r_q > QW'(24'h800000)) ? -24'sh800000 : $signed(24'd0 - r_q[23:0]);
        end
    end

    assign o_done = r_done;

endmodule

/* sv/wsm_parse.sv */
module wsm_parse import wsm_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_in                i_in,
    input  t_cmd               i_cmd,
    output t_pstat             o_stat,
    output logic signed [35:0] o_dividend,
    output logic [DIV_W-1:0]   o_divisor
);
    localparam logic [2:0] PH_HEAD = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_SKIP = 3'd2;
    localparam logic [2:0] PH_FMT  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_PAD  = 3'd5;
    localparam logic [2:0] PH_BAD  = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;

    localparam logic [30:0] FLT_LIM   = 31'd536870912;
    localparam logic [30:0] FLT_LIM_1 = 31'd536870911;

    logic [2:0]         r_phase, n_phase;
    logic [31:0]        r_bpos, n_bpos;
    logic [31:0]        r_tag, n_tag;
    logic [31:0]        r_rem, n_rem;
    logic [15:0]        r_fmt, n_fmt;
    logic [15:0]        r_chan, n_chan;
    logic [15:0]        r_depth, n_depth;
    logic [31:0]        r_rate, n_rate;
    logic [1:0]         r_seen, n_seen;
    logic [31:0]        r_asm, n_asm;
    logic signed [35:0] r_acc, n_acc;
    logic [15:0]        r_fpos, n_fpos;
    logic [31:0]        r_frames, n_frames;
    logic [3:0]         r_hdr, n_hdr;
    logic [4:0]         r_boff, n_boff;
    logic               r_odd, n_odd;
    logic [1:0]         r_sub, n_sub;

    logic               fmt_ok;
    logic               chan_ok;
    logic [2:0]         bps;
    logic [8:0]         fb;
    logic [34:0]        cap;
    logic               give;
    logic signed [35:0] sum;
    logic [2:0]         kind;
    logic [7:0]         b;
    logic [31:0]        a;
    logic [3:0]         st;

    function automatic logic signed [30:0] flt_q(input logic [31:0] f);
        logic [7:0]         e;
        logic [23:0]        m;
        logic [30:0]        mag;
        logic               lost;
        logic [7:0]         s;
        logic [31:0]        mw;
        logic signed [30:0] res;
        e    = f[30:23];
        m    = {(e != 8'd0), f[22:0]};
        mag  = '0;
        lost = 1'b0;
        res  = '0;
        mw   = {8'd0, m};
        if (e == 8'hFF) begin
            if (f[22:0] != 23'd0) res = '0;
            else res = f[31] ? -$signed(FLT_LIM) : $signed(FLT_LIM_1);
        end else begin
            if (e >= 8'd127) begin
                s = e - 8'd127;
                if (s >= 8'd6) mag = FLT_LIM;
                else mag = {7'd0, m} << s[2:0];
            end else begin
                s = (e != 8'd0) ? 8'd127 - e : 8'd126;
                if (s >= 8'd32) begin
                    mag  = '0;
                    lost = (m != 24'd0);
                end else begin
                    mag  = 31'(mw >> s[4:0]);
                    lost = (mw & ~(32'hFFFFFFFF << s[4:0])) != 32'd0;
                end
            end
            if (f[31]) begin
                mag = mag + 31'(lost);
                res = (mag > FLT_LIM) ? -$signed(FLT_LIM) : -$signed(mag);
            end else begin
                res = (mag > FLT_LIM_1) ? $signed(FLT_LIM_1) : $signed(mag);
            end
        end
        return res;
    endfunction

    function automatic logic signed [30:0] to_q(input logic [31:0] s_in,
                                                 input logic [15:0] fc,
                                                 input logic [15:0] dep);
        logic signed [30:0] v;
        if (fc == 16'd3) v = flt_q(s_in);
        else if (dep == 16'd16) v = $signed({{7{s_in[15]}}, s_in[15:0], 8'h00});
        else if (dep == 16'd24) v = $signed({{7{s_in[23]}}, s_in[23:0]});
        else v = $signed({{7{s_in[31]}}, s_in[31:8]});
        return v;
    endfunction

    assign b = i_in.file_byte;

    always_comb begin
        chan_ok = r_rate >= 32'd1000 && r_chan >= 16'd1 && r_chan <= 16'(MAX_CHANNELS);
        fmt_ok  = r_seen[0] && chan_ok &&
                  ((r_fmt == 16'd1 && (r_depth == 16'd16 || r_depth == 16'd24 ||
                                       r_depth == 16'd32)) ||
                   (r_fmt == 16'd3 && r_depth == 16'd32));
        bps = r_depth[5:3];
        unique case (bps)
            3'd2:    fb = {1'b0, r_chan[6:0], 1'b0};
            3'd3:    fb = {1'b0, r_chan[6:0], 1'b0} + {2'b0, r_chan[6:0]};
            default: fb = {r_chan[6:0], 2'b0};
        endcase
        cap = {1'b0, r_rate, 2'b0} + {3'b0, r_rate};
    end

    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_rem    = r_rem;
        n_fmt    = r_fmt;
        n_chan   = r_chan;
        n_depth  = r_depth;
        n_rate   = r_rate;
        n_seen   = r_seen;
        n_asm    = r_asm;
        n_acc    = r_acc;
        n_fpos   = r_fpos;
        n_frames = r_frames;
        n_hdr    = r_hdr;
        n_boff   = r_boff;
        n_odd    = r_odd;
        n_sub    = r_sub;
        give     = 1'b0;
        sum      = r_acc;
        kind     = PH_SKIP;
        a        = r_asm;
        n_bpos   = (&r_bpos) ? r_bpos : r_bpos + 32'd1;

        unique case (r_phase)
            PH_HEAD: begin
                n_tag = {b, r_tag[31:8]};
                if (r_bpos == 32'd3 && n_tag != TAG_RIFF) begin
                    n_phase = PH_BAD;
                end else if (r_bpos == 32'd11) begin
                    if (n_tag != TAG_WAVE) begin
                        n_phase = PH_BAD;
                    end else begin
                        n_phase = PH_CHDR;
                        n_hdr   = '0;
                    end
                end
            end
            PH_CHDR: begin
                if (r_hdr < 4'd4) n_tag = {b, r_tag[31:8]};
                else n_rem = {b, r_rem[31:8]};
                n_hdr = r_hdr + 4'd1;
                if (n_hdr >= 4'd8) begin
                    n_odd  = n_rem[0];
                    n_boff = '0;
                    if (n_tag == TAG_FMT && n_rem >= 32'd16 && r_seen == 2'd0) begin
                        kind = PH_FMT;
                    end else if (n_tag == TAG_DATA && r_seen == 2'd1) begin
                        kind   = PH_DATA;
                        n_fpos = '0;
                        n_acc  = '0;
                        n_asm  = '0;
                        n_sub  = '0;
                    end
                    if (n_rem == 32'd0) begin
                        if (kind == PH_FMT) n_seen[0] = 1'b1;
                        if (kind == PH_DATA) n_seen[1] = 1'b1;
                        n_phase = n_odd ? PH_PAD : PH_CHDR;
                        n_hdr   = '0;
                    end else begin
                        n_phase = kind;
                    end
                end
            end
            PH_SKIP, PH_FMT, PH_DATA: begin
                if (r_phase == PH_FMT) begin
                    if (r_boff < 5'd2) begin
                        if (r_boff[0]) n_fmt[15:8] = b;
                        else n_fmt[7:0] = b;
                    end else if (r_boff < 5'd4) begin
                        if (r_boff[0]) n_chan[15:8] = b;
                        else n_chan[7:0] = b;
                    end else if (r_boff < 5'd8) begin
                        unique case (r_boff[1:0])
                            2'd0: n_rate[7:0]   = b;
                            2'd1: n_rate[15:8]  = b;
                            2'd2: n_rate[23:16] = b;
                            default: n_rate[31:24] = b;
                        endcase
                    end else if (r_boff == 5'd14) begin
                        n_depth[7:0] = b;
                    end else if (r_boff == 5'd15) begin
                        n_depth[15:8] = b;
                    end
                end else if (r_phase == PH_DATA && fmt_ok) begin
                    a = (r_sub == 2'd0) ? 32'd0 : r_asm;
                    unique case (r_sub)
                        2'd0: a[7:0]   = b;
                        2'd1: a[15:8]  = b;
                        2'd2: a[23:16] = b;
                        default: a[31:24] = b;
                    endcase
                    n_asm = a;
                    if ({1'b0, r_sub} == bps - 3'd1) begin
                        sum   = r_acc + 36'(to_q(a, r_fmt, r_depth));
                        n_acc = sum;
                        n_sub = '0;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                    n_fpos = r_fpos + 16'd1;
                    if (n_fpos >= {7'd0, fb}) begin
                        n_acc  = '0;
                        n_fpos = '0;
                        n_sub  = '0;
                        if ({3'b0, r_frames} < cap) begin
                            give = 1'b1;
                            if (!(&r_frames)) n_frames = r_frames + 32'd1;
                        end
                    end
                end
                if (!(&r_boff)) n_boff = r_boff + 5'd1;
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    if (r_phase == PH_FMT) n_seen[0] = 1'b1;
                    if (r_phase == PH_DATA) n_seen[1] = 1'b1;
                    n_phase = r_odd ? PH_PAD : PH_CHDR;
                    n_hdr   = '0;
                end
            end
            PH_PAD: begin
                n_phase = PH_CHDR;
                n_hdr   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_phase  <= PH_HEAD;
            r_bpos   <= '0;
            r_tag    <= '0;
            r_rem    <= '0;
            r_fmt    <= '0;
            r_chan   <= '0;
            r_depth  <= '0;
            r_rate   <= '0;
            r_seen   <= '0;
            r_asm    <= '0;
            r_acc    <= '0;
            r_fpos   <= '0;
            r_frames <= '0;
            r_hdr    <= '0;
            r_boff   <= '0;
            r_odd    <= 1'b0;
            r_sub    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_bpos   <= n_bpos;
            r_tag    <= n_tag;
            r_rem    <= n_rem;
            r_fmt    <= n_fmt;
            r_chan   <= n_chan;
            r_depth  <= n_depth;
            r_rate   <= n_rate;
            r_seen   <= n_seen;
            r_asm    <= n_asm;
            r_acc    <= n_acc;
            r_fpos   <= n_fpos;
            r_frames <= n_frames;
            r_hdr    <= n_hdr;
            r_boff   <= n_boff;
            r_odd    <= n_odd;
            r_sub    <= n_sub;
        end
    end

    // end-of-file status from the settled state
    always_comb begin
        priority if (r_bpos < 32'd44) st = ST_SHORT;
        else if (r_phase == PH_BAD) st = ST_NOT_RIFF;
        else if (r_seen != 2'd3) st = ST_MISSING;
        else if (!chan_ok) st = ST_RATE_CH;
        else if (r_fmt != 16'd1 && r_fmt != 16'd3) st = ST_FORMAT;
        else if (r_depth < 16'd8) st = ST_DEPTH;
        else if (r_fmt == 16'd1 && !(r_depth == 16'd16 || r_depth == 16'd24 ||
                                    r_depth == 16'd32)) st = ST_PCM_DEP;
        else if (r_fmt == 16'd3 && r_depth != 16'd32) st = ST_FLT_DEP;
        else if (r_frames == 32'd0) st = ST_BAD_DATA;
        else if (r_frames == 32'd1) st = ST_FEW;
        else st = ST_OK;
    end

    assign o_stat.give   = give;
    assign o_stat.status = st;
    assign o_stat.rate   = (st == ST_OK) ? r_rate : 32'd0;
    assign o_dividend    = sum;
    assign o_divisor     = r_chan[DIV_W-1:0];

endmodule

/* sv/wsm_ctrl.sv */
module wsm_ctrl import wsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_eof,
    output logic               o_in_stall,
    output logic               o_accept,
    input  t_pstat             i_stat,
    output logic               o_div_start,
    input  logic               i_div_done,
    input  logic signed [23:0] i_div_q,
    output t_cmd               o_cmd,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output t_out               o_out
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_smp_pend;
    logic               r_eof_pend;
    logic signed [23:0] r_smp;
    logic               r_out_valid;
    t_out               r_out;
    logic               fin_load;

    // finish loads the output register once it is empty or being taken
    assign fin_load    = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_accept    = i_in_valid && !o_in_stall;
    assign o_div_start = o_accept && i_stat.give;
    assign o_cmd.clear = fin_load && r_eof_pend;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_accept && i_stat.give) n_state = S_DIV;
                else if (o_accept && i_eof) n_state = S_FIN;
            end
            S_DIV: begin
                if (i_div_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_smp_pend  <= 1'b0;
            r_eof_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_accept) begin
                r_smp_pend <= i_stat.give;
                r_eof_pend <= i_eof;
            end
            if (fin_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && i_div_done) r_smp <= i_div_q;
        if (fin_load) begin
            r_out.mono_sample  <= r_smp_pend ? r_smp : 24'sd0;
            r_out.sample_valid <= r_smp_pend;
            r_out.done_res     <= r_eof_pend;
            r_out.status       <= r_eof_pend ? i_stat.status : ST_OK;
            r_out.sample_rate  <= r_eof_pend ? i_stat.rate : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* sv/wav_stream_to_mono_samples_unit.sv */
// wav byte stream to mono q0.23 samples
// throughput: one byte per cycle for bytes that give no result, even while a result waits
// a byte that completes a frame holds the input through the 37-step shift-subtract divider,
//   its done strobe and the finish state, which loads the result into the output register
// a final byte without a frame holds the input through the finish state only; a result
//   still stalled in the output register extends the finish state. reset: synchronous i_rst_n
module wav_stream_to_mono_samples_unit import wsm_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    // handshake and sequencing
    logic               accept;
    logic               div_start;
    logic               div_done;
    logic signed [23:0] div_q;
    logic signed [35:0] dividend;
    logic [DIV_W-1:0]   divisor;
    t_pstat             pstat;
    t_cmd               cmd;

    // controller: idle / divide / finish, owns the output register
    wsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_eof       (i_in_data.end_of_file),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .i_stat      (pstat),
        .o_div_start (div_start),
        .i_div_done  (div_done),
        .i_div_q     (div_q),
        .o_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

    // parser datapath: tags, chunk walk, fmt capture, sample decode and channel sum
    wsm_parse #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (pstat),
        .o_dividend (dividend),
        .o_divisor  (divisor)
    );

    // floor division of the channel sum by the channel count, saturated to q0.23
    wsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

endmodule

/* sv/wsm_checker.sv */
module wsm_checker import wsm_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.sample_valid || o_out_data.done_res)
        else $error("result with neither sample nor done");

    a_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |->
            o_out_data.status == ST_OK && o_out_data.sample_rate == 32'd0)
        else $error("status or rate without done");

    a_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.sample_rate == 32'd0)
        else $error("rate given with error status");

endmodule

bind wav_stream_to_mono_samples_unit wsm_checker u_wsm_checker (.*);

/* dv/wav_checker.sv */
`timescale 1ns / 100ps

module wav_checker import wsm_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    typedef enum logic [3:0] {
        P_HEAD, P_CHDR, P_SKIP, P_FMT, P_DATA, P_PAD, P_BAD
    } t_phase;

    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam longint FLT_LIM = 64'sd1 << 29;
    localparam longint Q_MAX = 64'sd8388607;
    localparam longint Q_MIN = -64'sd8388608;

    t_phase      phase;
    logic [31:0] bpos, ctag, crem, rate, sasm, femit, boff;
    logic [15:0] fcode, chcnt, depth, fpos;
    logic [1:0]  seen;
    logic [3:0]  hcnt;
    logic        codd;
    longint      acc;

    t_out sample_q[$];

    function automatic logic [31:0] put_byte(logic [31:0] f, logic [7:0] b, int idx);
        logic [31:0] m;
        m = 32'hFF << (8 * (idx % 4));
        return (f & ~m) | ({24'b0, b} << (8 * (idx % 4)));
    endfunction

    function automatic longint flt_q23(logic [31:0] w);
        logic [31:0] e, m;
        longint mag;
        logic lost;
        int s;
        e = {24'b0, w[30:23]};
        m = {9'b0, w[22:0]};
        lost = 1'b0;
        if (e == 255) return (m != 0) ? 0 : (w[31] ? -FLT_LIM : FLT_LIM - 1);
        if (e != 0) m = m | 32'h800000;
        if (e >= 127) begin
            s = e - 127;
            mag = (s >= 6) ? FLT_LIM : (longint'(m) << s);
        end else begin
            s = (e != 0) ? 127 - e : 126;
            if (s >= 32) begin
                mag = 0;
                lost = m != 0;
            end else begin
                mag = longint'(m >> s);
                lost = (longint'(m) & ((64'sd1 << s) - 1)) != 0;
            end
        end
        if (w[31]) begin
            mag = mag + (lost ? 1 : 0);
            return (mag > FLT_LIM) ? -FLT_LIM : -mag;
        end
        return (mag > FLT_LIM - 1) ? FLT_LIM - 1 : mag;
    endfunction

    function automatic logic rate_ch_bad();
        return rate < 1000 || chcnt < 1 || chcnt > MAX_CHANNELS;
    endfunction

    function automatic logic fmt_usable();
        if (!seen[0] || rate_ch_bad()) return 1'b0;
        if (fcode == 1) return depth == 16 || depth == 24 || depth == 32;
        if (fcode == 3) return depth == 32;
        return 1'b0;
    endfunction

    function automatic logic [3:0] end_status();
        if (bpos < 44) return ST_SHORT;
        if (phase == P_BAD) return ST_NOT_RIFF;
        if (seen != 2'b11) return ST_MISSING;
        if (rate_ch_bad()) return ST_RATE_CH;
        if (fcode != 1 && fcode != 3) return ST_FORMAT;
        if (depth < 8) return ST_DEPTH;
        if (fcode == 1 && !(depth == 16 || depth == 24 || depth == 32)) return ST_PCM_DEP;
        if (fcode == 3 && depth != 32) return ST_FLT_DEP;
        if (femit == 0) return ST_BAD_DATA;
        if (femit == 1) return ST_FEW;
        return ST_OK;
    endfunction

    task automatic clear_state();
        phase = P_HEAD;
        bpos = '0; ctag = '0; crem = '0; rate = '0; sasm = '0; femit = '0; boff = '0;
        fcode = '0; chcnt = '0; depth = '0; fpos = '0; seen = '0; hcnt = '0; codd = 1'b0;
        acc = 0;
    endtask

    task automatic end_body(t_phase kind);
        if (kind == P_FMT) seen[0] = 1'b1;
        if (kind == P_DATA) seen[1] = 1'b1;
        phase = codd ? P_PAD : P_CHDR;
        hcnt = '0;
    endtask

    task automatic start_body();
        t_phase kind;
        kind = P_SKIP;
        codd = crem[0];
        boff = '0;
        if (ctag == TAG_FMT && crem >= 16 && seen == 0) begin
            kind = P_FMT;
        end else if (ctag == TAG_DATA && seen == 2'b01) begin
            kind = P_DATA;
            fpos = '0;
            acc = 0;
            sasm = '0;
        end
        if (crem == 0) end_body(kind);
        else phase = kind;
    endtask

    // one data byte; returns 1 with the averaged sample when a frame is given
    task automatic data_in(input logic [7:0] b, output logic have, output longint q);
        int bps, fbytes, sub;
        longint v, ch;
        logic give;
        have = 1'b0;
        q = 0;
        if (fmt_usable()) begin
            bps = depth / 8;
            fbytes = bps * chcnt;
            sub = fpos % bps;
            if (sub == 0) sasm = '0;
            sasm = put_byte(sasm, b, sub);
            if (sub == bps - 1) begin
                if (fcode == 3) v = flt_q23(sasm);
                else if (depth == 16) v = longint'(signed'(sasm[15:0])) * 256;
                else if (depth == 24) v = longint'(signed'(sasm[23:0]));
                else v = longint'(signed'(sasm[31:8]));
                acc = acc + v;
            end
            fpos = fpos + 16'd1;
            if (fpos >= fbytes) begin
                ch = longint'(chcnt);
                q = acc / ch;
                give = {32'b0, femit} < {32'b0, rate} * 64'd5;
                if (acc % ch != 0 && acc < 0) q = q - 1;
                if (q > Q_MAX) q = Q_MAX;
                if (q < Q_MIN) q = Q_MIN;
                acc = 0;
                fpos = '0;
                if (give) begin
                    if (femit != 32'hFFFFFFFF) femit = femit + 32'd1;
                    have = 1'b1;
                end
            end
        end
    endtask

    task automatic predict(input t_in req);
        logic [31:0] pos;
        logic        have;
        longint      q;
        t_out        res;
        pos = bpos;
        have = 1'b0;
        q = 0;
        if (bpos != 32'hFFFFFFFF) bpos = bpos + 32'd1;
        case (phase)
            P_HEAD: begin
                ctag = {req.file_byte, ctag[31:8]};
                if (pos == 3 && ctag != TAG_RIFF) begin
                    phase = P_BAD;
                end else if (pos == 11) begin
                    if (ctag != TAG_WAVE) phase = P_BAD;
                    else begin
                        phase = P_CHDR;
                        hcnt = '0;
                    end
                end
            end
            P_CHDR: begin
                if (hcnt < 4) ctag = {req.file_byte, ctag[31:8]};
                else crem = {req.file_byte, crem[31:8]};
                hcnt = hcnt + 4'd1;
                if (hcnt >= 8) start_body();
            end
            P_SKIP, P_FMT, P_DATA: begin
                if (phase == P_FMT) begin
                    if (boff < 2) fcode = 16'(put_byte(fcode, req.file_byte, boff));
                    else if (boff < 4)
                        chcnt = 16'(put_byte(chcnt, req.file_byte, boff - 2));
                    else if (boff < 8) rate = put_byte(rate, req.file_byte, boff - 4);
                    else if (boff == 14 || boff == 15)
                        depth = 16'(put_byte(depth, req.file_byte, boff - 14));
                end else if (phase == P_DATA) begin
                    data_in(req.file_byte, have, q);
                end
                if (boff != 32'hFFFFFFFF) boff = boff + 32'd1;
                crem = crem - 32'd1;
                if (crem == 0) end_body(phase);
            end
            P_PAD: begin
                phase = P_CHDR;
                hcnt = '0;
            end
            default: ;
        endcase
        res = '0;
        if (have) begin
            res.mono_sample = q[23:0];
            res.sample_valid = 1'b1;
        end
        if (req.end_of_file) begin
            res.done_res = 1'b1;
            res.status = end_status();
            res.sample_rate = (res.status == ST_OK) ? rate : 32'd0;
        end
        if (have || req.end_of_file) sample_q.insert(sample_q.size(), res);
        if (req.end_of_file) clear_state();
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_state();
            sample_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = sample_q.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected smp %h v %b d %b st %0d rate %h",
                                 $time, want.mono_sample, want.sample_valid, want.done_res,
                                 want.status, want.sample_rate);
                        $display("%0t:            actual smp %h v %b d %b st %0d rate %h",
                                 $time, i_out_data.mono_sample, i_out_data.sample_valid,
                                 i_out_data.done_res, i_out_data.status,
                                 i_out_data.sample_rate);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict(i_in_data);
        end
        o_pending <= sample_q.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import wsm_pkg::*;

    localparam int N_ITEMS = 800;
    localparam int IDLE_LIMIT = 4000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic in_valid = 0;
    logic out_stall = 0;
    t_in  in_data = '0;
    logic in_stall, out_valid;
    t_out out_data;
    int   errors, pending;
    int   idx = 0;
    int   idle_cycles = 0;
    int   n_req;

    logic [7:0] file_q[$];   // bytes of the file being built
    t_in        req_q[$];    // all requests in order

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    wav_stream_to_mono_samples_unit #(.MAX_CHANNELS(8)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    wav_checker #(.MAX_CHANNELS(8)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    // little-endian field writers
    task automatic put16(input logic [15:0] v);
        file_q.insert(file_q.size(), v[7:0]);
        file_q.insert(file_q.size(), v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    // move the built file into the request queue, flagging its last byte
    task automatic close_file();
        t_in r;
        foreach (file_q[i]) begin
            r.file_byte = file_q[i];
            r.end_of_file = (i == file_q.size() - 1);
            req_q.insert(req_q.size(), r);
        end
        file_q.delete();
    endtask

    // sample words biased toward extremes and float specials
    function automatic logic [31:0] sample_word();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            3: return 32'h7FFFFFFF;
            4: return 32'h7F800000;
            5: return 32'hFF800000;
            6: return 32'h7FC00000;
            7: return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
            8: return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // well-formed file with knobs for the odd cases
    task automatic make_wav(input int fcode, input int chans, input logic [31:0] rate,
                            input int depth, input int frames, input bit junk,
                            input bit data_first, input bit trunc, input bit bad_tag);
        int bps, nbytes, extra;
        logic [31:0] w;
        bps = depth / 8;
        extra = ($urandom_range(3) == 0) ? 1 : 0;
        nbytes = (bps > 0) ? frames * chans * bps + extra : frames + extra;
        put32(32'h46464952);
        put32($urandom);
        put32(32'h45564157);
        if (junk) begin
            // odd-sized chunk followed by a pad byte
            put32(32'h4B4E554A);
            put32(32'd3);
            repeat (4) file_q.insert(file_q.size(), 8'($urandom));
        end
        if (data_first) begin
            put32(32'h61746164);
            put32(32'd4);
            put32($urandom);
        end
        put32(32'h20746D66);
        put32(32'd16);
        put16(16'(fcode));
        put16(16'(chans));
        put32(rate);
        put32($urandom);
        put16(16'($urandom));
        put16(16'(depth));
        put32(32'h61746164);
        put32(32'(nbytes));
        if (bps > 0) begin
            repeat (frames * chans) begin
                w = sample_word();
                if (fcode != 3) w = w >> (32 - depth);
                for (int k = 0; k < bps; k++) file_q.insert(file_q.size(), 8'(w >> (8 * k)));
            end
            repeat (extra) file_q.insert(file_q.size(), 8'($urandom));
        end else begin
            repeat (nbytes) file_q.insert(file_q.size(), 8'($urandom));
        end
        if (junk && $urandom_range(1)) begin
            // trailing odd chunk after data
            put32(32'h5453494C);
            put32(32'd1);
            put16(16'($urandom));
        end
        if (trunc) repeat ($urandom_range(1, 3)) void'(file_q.pop_back());
        if (bad_tag) file_q[$urandom_range(11)] ^= 8'h01 << $urandom_range(7);
        close_file();
    endtask

    task automatic make_noise(input int len);
        repeat (len) file_q.insert(file_q.size(), 8'($urandom));
        close_file();
    endtask

    task automatic make_random_file();
        int fc, ch, dep, sel;
        logic [31:0] rate;
        sel = $urandom_range(99);
        if (sel < 8) begin
            make_noise($urandom_range(1, 60));
        end else begin
            fc = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : ($urandom_range(1) ? 1 : 3);
            ch = ($urandom_range(9) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 8);
            case ($urandom_range(3))
                0: dep = 16;
                1: dep = 24;
                2: dep = 32;
                default: dep = ($urandom_range(4) == 0) ? $urandom_range(0, 40) : 32;
            endcase
            if (fc == 3 && $urandom_range(1)) dep = 32;
            case ($urandom_range(9))
                0: rate = $urandom_range(0, 999);
                1: rate = 32'hFFFFFFFF;
                default: rate = $urandom_range(1000, 96000);
            endcase
            make_wav(fc, ch, rate, dep, $urandom_range(0, 6), $urandom_range(3) == 0,
                     $urandom_range(7) == 0, $urandom_range(9) == 0,
                     $urandom_range(19) == 0);
        end
    endtask

    // receiver stalls at random, except in the quiet stretch
    always @(posedge i_clk) begin
        if (idx >= 300 && idx < 500) out_stall <= 0;
        else out_stall <= ($urandom_range(99) < 13);
    end

    // no-progress watchdog
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // directed files
        make_wav(1, 2, 44100, 16, 4, 0, 0, 0, 0);
        make_wav(1, 1, 1000, 24, 3, 1, 0, 0, 0);
        make_wav(1, 8, 48000, 32, 2, 0, 0, 0, 0);
        make_wav(3, 2, 32'hFFFFFFFF, 32, 3, 0, 0, 0, 0);
        make_wav(3, 1, 8000, 32, 4, 1, 1, 0, 0);
        make_wav(1, 2, 8000, 16, 3, 0, 0, 1, 0);
        make_wav(1, 2, 8000, 16, 3, 0, 0, 0, 1);
        make_noise(1);
        // random files, mostly well formed
        while (req_q.size() < N_ITEMS) make_random_file();
        n_req = req_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        while (idx < n_req) begin
            @(posedge i_clk);
            if (in_valid && !in_stall) idx = idx + 1;
            if (!in_valid || !in_stall) begin
                if (idx >= n_req) begin
                    in_valid <= 0;
                end else if (!(idx >= 300 && idx < 500) && $urandom_range(99) < 13) begin
                    in_valid <= 0;
                end else begin
                    in_valid <= 1;
                    in_data <= req_q[idx];
                end
            end
        end

        // let the last prediction land, drain, then watch for stray results
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* wav_stream_to_mono_samples_unit.f */
sv/wsm_pkg.sv
sv/wsm_div.sv
sv/wsm_parse.sv
sv/wsm_ctrl.sv
sv/wav_stream_to_mono_samples_unit.sv
sv/wsm_checker.sv
dv/wav_checker.sv
dv/testbench.sv
